### hw/rtl/dlm_pkg.sv
// Shared constants, types and codes for the dense layer matrix-vector block.
`default_nettype none

package dlm_pkg;

    localparam int IN_MAX  = 64;
    localparam int OUT_MAX = 64;

    localparam int VAL_W      = 16;
    localparam int ACC_W      = 32;
    localparam int SIZE_W     = 7;
    localparam int IDX_W      = 6;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int BIAS_SHIFT = 8;

    localparam int K_W     = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam int CNT_W   = $clog2(IN_MAX + 1);
    localparam int WDEPTH  = IN_MAX * OUT_MAX;
    localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_SIZE  = 2'd0,
        CFG_OUTPUT_SIZE = 2'd1,
        CFG_USE_BIAS    = 2'd2,
        CFG_ACCUMULATE  = 2'd3
    } cfg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_WEIGHT = 2'd0,
        KIND_BIAS   = 2'd1,
        KIND_ELEM   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        OP_PREP,
        OP_MAC,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_PREP_W,
        ST_SEL,
        ST_MAC,
        ST_MAC_W,
        ST_STEP,
        ST_EMIT,
        ST_EMIT_W
    } state_t;

    typedef struct packed {
        logic write_weight;
        logic write_bias;
        logic load_elem;
        logic issue;
        op_t  op;
        logic count_step;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic x_nonzero;
        logic last_k;
        logic vec_end;
        logic pipe_empty;
    } status_t;

endpackage

`default_nettype wire

### hw/rtl/dense_layer_matvec.sv
// Top level of the fixed-point dense layer matrix-vector block.
`default_nettype none
// Usage:
//   An item is taken when start is high and busy is low. kind selects a
//   weight write (in_index row, out_index column), a bias write (out_index)
//   or one input-vector element (value, Q8.8). Table writes leave busy low.
//   Each element is worked by one shared multiply-accumulate that walks the
//   active outputs (N = clamped output_size), one per cycle, through the
//   accumulator RAM. A zero element skips the multiply pass; the first
//   element of a vector adds a bias pass before it and the last element a
//   result pass after it.
//   After the last element, N results come out on consecutive cycles, each
//   marked by result_valid for one cycle; last flags the final one. The
//   receiver takes every beat and cannot stall the block.
//   Configuration writes go through cfg_valid/cfg_ready (always ready); the
//   user must make them only while busy is low; the block does not enforce it.
//   Reset clears the element counter and all accumulators and loads the
//   register defaults; weight and bias tables stay undefined until written.
module dense_layer_matvec (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic        [dlm_pkg::KIND_W-1:0]   kind,
    input  wire logic        [dlm_pkg::IDX_W-1:0]    in_index,
    input  wire logic        [dlm_pkg::IDX_W-1:0]    out_index,
    input  wire logic signed [dlm_pkg::VAL_W-1:0]    value,
    output logic                                     result_valid,
    output logic             [dlm_pkg::IDX_W-1:0]    result_index,
    output logic signed      [dlm_pkg::ACC_W-1:0]    out_value,
    output logic                                     last,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic        [dlm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [dlm_pkg::SIZE_W-1:0]   cfg_data
);

    import dlm_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    dlm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    dlm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_index     (in_index),
        .out_index    (out_index),
        .value        (value),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_index (result_index),
        .out_value    (out_value),
        .last         (last)
    );

    a_result_while_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> busy
    ) else $error("result beat outside an item");

    a_gap_after_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && last) |=> !result_valid
    ) else $error("result beat follows the last beat");

    a_table_write_single: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_WEIGHT || kind == KIND_BIAS)) |=> !busy
    ) else $error("table write left the block busy");

endmodule

`default_nettype wire

### hw/rtl/dlm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module dlm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/dlm_ctrl.sv
// Controller state machine: sequences the bias, multiply and result passes.
`default_nettype none

module dlm_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [dlm_pkg::KIND_W-1:0]  kind,
    input  wire dlm_pkg::status_t            status,
    output logic                             busy,
    output dlm_pkg::cmd_t                    cmd
);

    import dlm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd              = '0;
        cmd.op           = OP_PREP;
        busy             = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    priority if (kind == KIND_WEIGHT)
                    begin
                        cmd.write_weight = 1'b1;
                    end
                    else if (kind == KIND_BIAS)
                    begin
                        cmd.write_bias = 1'b1;
                    end
                    else if (kind == KIND_ELEM)
                    begin
                        cmd.load_elem = 1'b1;
                        state_next    = status.count_zero ? ST_PREP : ST_SEL;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.issue = 1'b1;
                cmd.op    = OP_PREP;
                if (status.last_k)
                begin
                    state_next = ST_PREP_W;
                end
            end
            ST_PREP_W:
            begin
                if (status.pipe_empty)
                begin
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                state_next = status.x_nonzero ? ST_MAC : ST_STEP;
            end
            ST_MAC:
            begin
                cmd.issue = 1'b1;
                cmd.op    = OP_MAC;
                if (status.last_k)
                begin
                    state_next = ST_MAC_W;
                end
            end
            ST_MAC_W:
            begin
                if (status.pipe_empty)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.count_step = 1'b1;
                state_next     = status.vec_end ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                cmd.issue = 1'b1;
                cmd.op    = OP_EMIT;
                if (status.last_k)
                begin
                    state_next = ST_EMIT_W;
                end
            end
            ST_EMIT_W:
            begin
                if (status.pipe_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/dlm_dp.sv
// Datapath: tables, accumulators, shared multiply-accumulate pipeline, result registers.
`default_nettype none

module dlm_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire dlm_pkg::cmd_t                      cmd,
    output dlm_pkg::status_t                        status,
    input  wire logic        [dlm_pkg::IDX_W-1:0]   in_index,
    input  wire logic        [dlm_pkg::IDX_W-1:0]   out_index,
    input  wire logic signed [dlm_pkg::VAL_W-1:0]   value,
    input  wire logic                               cfg_valid,
    input  wire logic        [dlm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [dlm_pkg::SIZE_W-1:0]  cfg_data,
    output logic                                    result_valid,
    output logic             [dlm_pkg::IDX_W-1:0]   result_index,
    output logic signed      [dlm_pkg::ACC_W-1:0]   out_value,
    output logic                                    last
);

    import dlm_pkg::*;

    logic [SIZE_W-1:0] input_size_reg;
    logic [SIZE_W-1:0] output_size_reg;
    logic              use_bias_reg;
    logic              accumulate_reg;

    logic [SIZE_W-1:0] isz;
    logic [SIZE_W-1:0] osz;

    logic [CNT_W-1:0]  count_reg;
    logic [K_W-1:0]    k_reg;
    logic signed [VAL_W-1:0] x_reg;
    logic [OUT_MAX-1:0] acc_valid_reg;

    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic [K_W-1:0]    s1_k_reg;
    logic              s1_accv_reg;

    logic              s2_valid_reg;
    logic [K_W-1:0]    s2_k_reg;
    logic signed [ACC_W-1:0] s2_base_reg;
    logic signed [ACC_W-1:0] s2_add_reg;

    logic              result_valid_reg;
    logic [IDX_W-1:0]  result_index_reg;
    logic signed [ACC_W-1:0] out_value_reg;
    logic              last_reg;

    logic              last_k;
    logic              vec_end;

    logic signed [VAL_W-1:0]   w_q;
    logic signed [VAL_W-1:0]   b_q;
    logic [ACC_W-1:0]          acc_q;
    logic signed [ACC_W-1:0]   acc1;
    logic signed [2*VAL_W-1:0] prod;
    logic signed [ACC_W-1:0]   bias_ext;
    logic signed [ACC_W-1:0]   base_next;
    logic signed [ACC_W-1:0]   add_next;
    logic signed [ACC_W:0]     sum;
    logic signed [ACC_W-1:0]   sat_sum;

    logic              w_we;
    logic [WADDR_W-1:0] w_waddr;
    logic [WADDR_W-1:0] w_raddr;
    logic              b_we;

    always_comb
    begin
        if (input_size_reg == '0)
        begin
            isz = SIZE_W'(1);
        end
        else if (int'(input_size_reg) > IN_MAX)
        begin
            isz = SIZE_W'(IN_MAX);
        end
        else
        begin
            isz = input_size_reg;
        end
        if (output_size_reg == '0)
        begin
            osz = SIZE_W'(1);
        end
        else if (int'(output_size_reg) > OUT_MAX)
        begin
            osz = SIZE_W'(OUT_MAX);
        end
        else
        begin
            osz = output_size_reg;
        end
    end

    assign last_k  = (int'(k_reg) == int'(osz) - 1);
    assign vec_end = (int'(count_reg) + 1 >= int'(isz));

    assign status.count_zero = (count_reg == '0);
    assign status.x_nonzero  = (x_reg != '0) && (int'(count_reg) < IN_MAX);
    assign status.last_k     = last_k;
    assign status.vec_end    = vec_end;
    assign status.pipe_empty = !s1_valid_reg && !s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_size_reg  <= SIZE_W'(64);
            output_size_reg <= SIZE_W'(64);
            use_bias_reg    <= 1'b1;
            accumulate_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_INPUT_SIZE:  input_size_reg  <= cfg_data;
                CFG_OUTPUT_SIZE: output_size_reg <= cfg_data;
                CFG_USE_BIAS:    use_bias_reg    <= cfg_data[0];
                CFG_ACCUMULATE:  accumulate_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign w_we    = cmd.write_weight && (int'(in_index) < IN_MAX)
                     && (int'(out_index) < OUT_MAX);
    assign w_waddr = WADDR_W'(int'(in_index) * OUT_MAX + int'(out_index));
    assign w_raddr = WADDR_W'(int'(count_reg) * OUT_MAX + int'(k_reg));
    assign b_we    = cmd.write_bias && (int'(out_index) < OUT_MAX);

    dlm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (WDEPTH)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (value),
        .raddr (w_raddr),
        .rdata (w_q)
    );

    dlm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (OUT_MAX)
    ) u_bias_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (K_W'(out_index)),
        .wdata (value),
        .raddr (k_reg),
        .rdata (b_q)
    );

    dlm_ram #(
        .WIDTH (ACC_W),
        .DEPTH (OUT_MAX)
    ) u_acc_ram (
        .clk   (clk),
        .we    (s2_valid_reg),
        .waddr (s2_k_reg),
        .wdata (sat_sum),
        .raddr (k_reg),
        .rdata (acc_q)
    );

    // stage 1: registered reads arrive, multiply, bias select or accumulator read-out
    always_comb
    begin
        acc1     = s1_accv_reg ? signed'(acc_q) : '0;
        prod     = x_reg * w_q;
        bias_ext = {{(ACC_W-VAL_W-BIAS_SHIFT){b_q[VAL_W-1]}}, b_q, {BIAS_SHIFT{1'b0}}};
        unique case (s1_op_reg)
            OP_MAC:
            begin
                base_next = acc1;
                add_next  = ACC_W'(prod);
            end
            OP_PREP:
            begin
                base_next = accumulate_reg ? acc1 : '0;
                add_next  = use_bias_reg ? bias_ext : '0;
            end
            default:
            begin
                base_next = acc1;
                add_next  = '0;
            end
        endcase
    end

    // stage 2: saturating add, write back
    always_comb
    begin
        sum = {s2_base_reg[ACC_W-1], s2_base_reg} + {s2_add_reg[ACC_W-1], s2_add_reg};
        if (sum[ACC_W] != sum[ACC_W-1])
        begin
            sat_sum = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            sat_sum = sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            k_reg            <= '0;
            acc_valid_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.count_step)
            begin
                count_reg <= vec_end ? '0 : count_reg + 1'b1;
            end
            if (cmd.issue)
            begin
                k_reg <= last_k ? '0 : k_reg + 1'b1;
            end
            if (s2_valid_reg)
            begin
                acc_valid_reg[s2_k_reg] <= 1'b1;
            end
            s1_valid_reg     <= cmd.issue;
            s2_valid_reg     <= s1_valid_reg && (s1_op_reg != OP_EMIT);
            result_valid_reg <= s1_valid_reg && (s1_op_reg == OP_EMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_elem)
        begin
            x_reg <= value;
        end
        s1_op_reg        <= cmd.op;
        s1_k_reg         <= k_reg;
        s1_accv_reg      <= acc_valid_reg[k_reg];
        s2_k_reg         <= s1_k_reg;
        s2_base_reg      <= base_next;
        s2_add_reg       <= add_next;
        result_index_reg <= IDX_W'(s1_k_reg);
        out_value_reg    <= acc1;
        last_reg         <= (int'(s1_k_reg) == int'(osz) - 1);
    end

    assign result_valid = result_valid_reg;
    assign result_index = result_index_reg;
    assign out_value    = out_value_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the fixed-point dense layer matrix-vector block.
module testbench;
    import dlm_pkg::*;

    localparam int unsigned LIMIT_CYCLES  = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 3 * OUT_MAX + 16;
    localparam int unsigned RANDOM_ITEMS  = 220;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [ACC_W-1:0] sum;
        logic             is_last;
    } neuron_out_t;

    typedef struct packed {
        logic              is_cfg;
        cfg_reg_t          reg_sel;
        logic [SIZE_W-1:0] reg_data;
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [VAL_W-1:0]  val;
        logic              known_en;
        logic [ACC_W-1:0]  known_sum;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [29] = '{
        '{1'b1, CFG_INPUT_SIZE,  7'd1,   KIND_WEIGHT, 6'd0,  6'd0,  16'h0000, 1'b0, 32'h0},
        '{1'b1, CFG_OUTPUT_SIZE, 7'd1,   KIND_WEIGHT, 6'd0,  6'd0,  16'h0000, 1'b0, 32'h0},
        '{1'b0, CFG_INPUT_SIZE,  7'd0,   KIND_WEIGHT, 6'd0,  6'd0,  16'h7FFF, 1'b0, 32'h0},
        '{1'b0, CFG_INPUT_SIZE,  7'd0,   KIND_BIAS,   6'd0,  6'd0,  16'h0100, 1'b0, 32'h0},
        '{1'b0, CFG_INPUT_SIZE,  7'd0,   KIND_ELEM,   6'd0,  6'd0,  16'h8000, 1'b1,
          32'hC001_8000},
        '{1'b0, CFG_INPUT_SIZE,  7'd0,   KIND_ELEM,   6'd63, 6'd63, 16'h0000, 1'b1,
          32'h0001_0000},
        '{1'b1, CFG_USE_BIAS,    7'd0,   KIND_WEIGHT, 6'd0,  6'd0,  16'h0000, 1'b0, 32'h0},
        '{1'b0, CFG_INPUT_SIZE,  7'd0,   KIND_ELEM,   6'd0,  6'd0,  16'h0100, 1'b1,
          32'h007F_FF00},
        '{1'b1, CFG_ACCUMULATE,  7'd1,   KIND_WEIGHT, 6'd0,  6'd0,  16'h0000, 1'b0, 32'h0},
        '{1'b0, CFG_INPUT_SIZE,  7'd0,   KIND_ELEM,   6'd0,  6'd0,  16'h7FFF, 1'b1,
          32'h407E_FF01},
        '{1'b0, CFG_INPUT_SIZE,  7'd0,   KIND_ELEM,   6'd0,  6'd0,  16'h7FFF, 1'b1,
          32'h7FFF_FFFF},
        '{1'b1, CFG_USE_BIAS,    7'd1,   KIND_WEIGHT, 6'd0,  6'd0,  16'h0000, 1'b0, 32'h0},
        '{1'b0, CFG_INPUT_SIZE,  7'd0,   KIND_BIAS,   6'd0,  6'd0,  16'h8000, 1'b0, 32'h0},
        '{1'b0, CFG_INPUT_SIZE,  7'd0,   KIND_ELEM,   6'd0,  6'd0,  16'h0000, 1'b1,
          32'h7F7F_FFFF},
        '{1'b0, CFG_INPUT_SIZE,  7'd0,   KIND_WEIGHT, 6'd63, 6'd63, 16'h8000, 1'b0, 32'h0},
        '{1'b0, CFG_INPUT_SIZE,  7'd0,   KIND_BIAS,   6'd63, 6'd63, 16'h7FFF, 1'b0, 32'h0},
        '{1'b0, CFG_INPUT_SIZE,  7'd0,   KIND_UNUSED, 6'd63, 6'd63, 16'hFFFF, 1'b0, 32'h0},
        '{1'b1, CFG_ACCUMULATE,  7'd0,   KIND_WEIGHT, 6'd0,  6'd0,  16'h0000, 1'b0, 32'h0},
        '{1'b1, CFG_INPUT_SIZE,  7'd0,   KIND_WEIGHT, 6'd0,  6'd0,  16'h0000, 1'b0, 32'h0},
        '{1'b1, CFG_OUTPUT_SIZE, 7'd127, KIND_WEIGHT, 6'd0,  6'd0,  16'h0000, 1'b0, 32'h0},
        '{1'b0, CFG_INPUT_SIZE,  7'd0,   KIND_ELEM,   6'd0,  6'd0,  16'hFFFF, 1'b0, 32'h0},
        '{1'b1, CFG_INPUT_SIZE,  7'd4,   KIND_WEIGHT, 6'd0,  6'd0,  16'h0000, 1'b0, 32'h0},
        '{1'b1, CFG_OUTPUT_SIZE, 7'd0,   KIND_WEIGHT, 6'd0,  6'd0,  16'h0000, 1'b0, 32'h0},
        '{1'b0, CFG_INPUT_SIZE,  7'd0,   KIND_ELEM,   6'd0,  6'd0,  16'h0001, 1'b0, 32'h0},
        '{1'b0, CFG_INPUT_SIZE,  7'd0,   KIND_ELEM,   6'd0,  6'd0,  16'h8000, 1'b0, 32'h0},
        '{1'b1, CFG_INPUT_SIZE,  7'd2,   KIND_WEIGHT, 6'd0,  6'd0,  16'h0000, 1'b0, 32'h0},
        '{1'b0, CFG_INPUT_SIZE,  7'd0,   KIND_ELEM,   6'd0,  6'd0,  16'h1234, 1'b0, 32'h0},
        '{1'b0, CFG_INPUT_SIZE,  7'd0,   KIND_ELEM,   6'd0,  6'd0,  16'h0000, 1'b0, 32'h0},
        '{1'b0, CFG_INPUT_SIZE,  7'd0,   KIND_ELEM,   6'd0,  6'd0,  16'h7FFF, 1'b0, 32'h0}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [KIND_W-1:0]        kind;
    logic [IDX_W-1:0]         in_index;
    logic [IDX_W-1:0]         out_index;
    logic signed [VAL_W-1:0]  value;
    logic                     result_valid;
    logic [IDX_W-1:0]         result_index;
    logic signed [ACC_W-1:0]  out_value;
    logic                     last;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [SIZE_W-1:0]        cfg_data;
    logic                     known_en;
    logic [ACC_W-1:0]         known_sum;

    logic signed [VAL_W-1:0]  weight_model [WDEPTH];
    logic signed [VAL_W-1:0]  bias_model [OUT_MAX];
    logic signed [ACC_W-1:0]  sum_model [OUT_MAX];
    int unsigned              elem_pos;
    logic [SIZE_W-1:0]        in_size_reg;
    logic [SIZE_W-1:0]        out_size_reg;
    logic                     bias_on;
    logic                     accum_on;
    neuron_out_t              due_outputs [$];
    int unsigned              fail_count = 0;
    int unsigned              cycle_count;

    dense_layer_matvec dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .in_index     (in_index),
        .out_index    (out_index),
        .value        (value),
        .result_valid (result_valid),
        .result_index (result_index),
        .out_value    (out_value),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_sum(logic signed [ACC_W-1:0] a, longint b);
        longint s;
        s = longint'(a) + b;
        if (s > SUM_MAX)
            s = SUM_MAX;
        if (s < SUM_MIN)
            s = SUM_MIN;
        return s[ACC_W-1:0];
    endfunction

    task automatic layer_forward(input logic [KIND_W-1:0] k_in, input logic [IDX_W-1:0] row,
                                 input logic [IDX_W-1:0] col, input logic signed [VAL_W-1:0] x,
                                 input logic use_known, input logic [ACC_W-1:0] known_val);
        int unsigned isz;
        int unsigned osz;
        int unsigned k;
        longint b;
        neuron_out_t item;
        isz = clamp_size(in_size_reg, IN_MAX);
        osz = clamp_size(out_size_reg, OUT_MAX);
        if (k_in == KIND_WEIGHT)
        begin
            if (row < IN_MAX && col < OUT_MAX)
                weight_model[row * OUT_MAX + col] = x;
            return;
        end
        if (k_in == KIND_BIAS)
        begin
            if (col < OUT_MAX)
                bias_model[col] = x;
            return;
        end
        if (k_in != KIND_ELEM)
            return;
        if (elem_pos == 0)
        begin
            for (k = 0; k < osz; k++)
            begin
                b = longint'(bias_model[k]) <<< BIAS_SHIFT;
                if (bias_on)
                begin
                    if (accum_on)
                        sum_model[k] = sat_sum(sum_model[k], b);
                    else
                        sum_model[k] = b[ACC_W-1:0];
                end
                else if (!accum_on)
                    sum_model[k] = '0;
            end
        end
        if (x != 0 && elem_pos < IN_MAX)
        begin
            for (k = 0; k < osz; k++)
                sum_model[k] = sat_sum(sum_model[k],
                    longint'(weight_model[elem_pos * OUT_MAX + k]) * longint'(x));
        end
        elem_pos++;
        if (elem_pos >= isz)
        begin
            elem_pos = 0;
            for (k = 0; k < osz; k++)
            begin
                item.index   = k[IDX_W-1:0];
                item.sum     = (k == 0 && use_known) ? known_val : sum_model[k];
                item.is_last = (k == osz - 1);
                due_outputs.push_back(item);
            end
        end
    endtask

    always @(posedge clk)
    begin : monitor
        neuron_out_t got;
        neuron_out_t want;
        if (rst_n)
        begin
            if (result_valid)
            begin
                got = '{result_index, out_value, last};
                if (due_outputs.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got neuron %0d value %h last %b",
                             $time, result_index, out_value, last);
                    fail_count++;
                end
                else
                begin
                    want = due_outputs.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: expected neuron %0d value %h last %b, got neuron %0d value %h last %b",
                                 $time, want.index, want.sum, want.is_last,
                                 got.index, got.sum, got.is_last);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_INPUT_SIZE:  in_size_reg  = cfg_data;
                    CFG_OUTPUT_SIZE: out_size_reg = cfg_data;
                    CFG_USE_BIAS:    bias_on      = cfg_data[0];
                    CFG_ACCUMULATE:  accum_on     = cfg_data[0];
                endcase
            end
            if (start && !busy)
                layer_forward(kind, in_index, out_index, value, known_en, known_sum);
        end
    end

    function automatic int unsigned pick_gap(logic quiet);
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VAL_W-1:0] pick_element();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return 16'h8000;
            2:       return 16'h7FFF;
            3:       return VAL_W'($urandom_range(0, 511));
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // hold start high across back-to-back beats
    task automatic send_item(input logic [KIND_W-1:0] k_in, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] x,
                             input logic k_en, input logic [ACC_W-1:0] k_sum,
                             input int unsigned gap);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        kind      <= k_in;
        in_index  <= row;
        out_index <= col;
        value     <= x;
        known_en  <= k_en;
        known_sum <= k_sum;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic settle_block();
        start <= 1'b0;
        @(negedge clk);
        while (due_outputs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_reg(input cfg_reg_t sel, input logic [SIZE_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned i;
        int unsigned r;
        int unsigned phase;
        int unsigned nvec;
        int unsigned vec_len;
        int unsigned items_sent;
        logic quiet;
        logic [SIZE_W-1:0] isz_pick;
        logic [SIZE_W-1:0] osz_pick;
        stim_row_t row_now;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        kind      <= KIND_WEIGHT;
        in_index  <= '0;
        out_index <= '0;
        value     <= '0;
        known_en  <= 1'b0;
        known_sum <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_INPUT_SIZE;
        cfg_data  <= '0;
        for (i = 0; i < WDEPTH; i++)
            weight_model[i] = '0;
        for (i = 0; i < OUT_MAX; i++)
        begin
            bias_model[i] = '0;
            sum_model[i]  = '0;
        end
        elem_pos     = 0;
        in_size_reg  = 7'd64;
        out_size_reg = 7'd64;
        bias_on      = 1'b1;
        accum_on     = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill both tables so no unwritten entry is ever read
        for (i = 0; i < WDEPTH; i++)
            send_item(KIND_WEIGHT, IDX_W'(i / OUT_MAX), IDX_W'(i % OUT_MAX),
                      VAL_W'($urandom), 1'b0, '0, 0);
        for (i = 0; i < OUT_MAX; i++)
            send_item(KIND_BIAS, IDX_W'($urandom), IDX_W'(i), VAL_W'($urandom), 1'b0, '0, 0);

        foreach (DIRECTED_ROWS[n])
        begin
            row_now = DIRECTED_ROWS[n];
            if (row_now.is_cfg)
            begin
                settle_block();
                program_reg(row_now.reg_sel, row_now.reg_data);
            end
            else
                send_item(row_now.kind, row_now.row, row_now.col, row_now.val,
                          row_now.known_en, row_now.known_sum, pick_gap(1'b0));
        end

        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 19);
            if (phase == 0 || r == 2)
                isz_pick = 7'd64;
            else if (r == 0)
                isz_pick = '0;
            else if (r == 1)
                isz_pick = 7'd127;
            else if (r == 3)
                isz_pick = SIZE_W'($urandom_range(0, 127));
            else
                isz_pick = SIZE_W'($urandom_range(1, 8));
            r = $urandom_range(0, 9);
            if (phase == 0)
                osz_pick = 7'd64;
            else if (r == 0)
                osz_pick = '0;
            else if (r == 1)
                osz_pick = 7'd127;
            else if (r == 2)
                osz_pick = SIZE_W'($urandom_range(0, 127));
            else
                osz_pick = SIZE_W'($urandom_range(1, 16));

            settle_block();
            program_reg(CFG_INPUT_SIZE, isz_pick);
            program_reg(CFG_OUTPUT_SIZE, osz_pick);
            program_reg(CFG_USE_BIAS, SIZE_W'($urandom));
            program_reg(CFG_ACCUMULATE, SIZE_W'($urandom));

            quiet = ($urandom_range(0, 3) == 0);
            nvec = (phase == 0) ? 1 : $urandom_range(1, 4);
            repeat (nvec)
            begin
                vec_len = clamp_size(isz_pick, IN_MAX);
                // drop the tail of some vectors so the next phase starts mid-vector
                if ($urandom_range(0, 6) == 0)
                    vec_len = $urandom_range(1, vec_len);
                repeat (vec_len)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 8)
                    begin
                        send_item(KIND_WEIGHT, IDX_W'($urandom), IDX_W'($urandom),
                                  VAL_W'($urandom), 1'b0, '0, pick_gap(quiet));
                        items_sent++;
                    end
                    else if (r < 11)
                    begin
                        send_item(KIND_BIAS, IDX_W'($urandom), IDX_W'($urandom),
                                  VAL_W'($urandom), 1'b0, '0, pick_gap(quiet));
                        items_sent++;
                    end
                    else if (r < 13)
                        send_item(KIND_UNUSED, IDX_W'($urandom), IDX_W'($urandom),
                                  VAL_W'($urandom), 1'b0, '0, pick_gap(quiet));
                    send_item(KIND_ELEM, IDX_W'($urandom), IDX_W'($urandom),
                              pick_element(), 1'b0, '0, pick_gap(quiet));
                    items_sent++;
                end
            end
            phase++;
        end

        settle_block();
        if (fail_count == 0 && due_outputs.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
